FILE: sv/c2s_pkg.sv
// Shared types, widths and constants for the Cartesian-to-spherical converter.
`timescale 1ns / 1ps

package c2s_pkg;

    localparam int DW              = 34;
    localparam int AW              = 34;
    localparam int UW              = DW - 1;
    localparam int GW              = 30;
    localparam int PW              = UW + GW;
    localparam int SIDE_W          = 16;
    localparam int FRAC_BITS       = 14;
    localparam int MAX_ITER        = 24;
    localparam int CORDIC_ITER_DEF = 16;

    localparam logic [GW-1:0] INV_GAIN = 30'd652032874;

    localparam logic signed [AW-1:0] ANG_PI      = 34'sd2147483648;
    localparam logic signed [AW-1:0] ANG_HALF_PI = 34'sd1073741824;

    localparam logic signed [AW-1:0] ATAN_TAB [MAX_ITER] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10680862,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 on_axis;
        logic                 neg_axis;
    } cvec_t;

endpackage

FILE: sv/cartesian_to_spherical_vector.sv
// Top level of the pipelined Cartesian-to-spherical vector converter.
//
// Channel   Dir  Fields (low bit first)                                Transfer when
// s_axis    in   tdata: vec_x[15:0] vec_y[31:16] vec_z[47:32]          s_tvalid & s_tready
// m_axis    out  tdata: magnitude[15:0] polar_angle[31:16]
//                       azimuth_angle[47:32]                           m_tvalid & m_tready
//
// One vector enters per cycle unless m_tready holds the output; a vector passes entry,
// micro-rotation and gain registers for each of the two chains, then the output register.
// Each cell holds its result while the next cell is full and stalled, so gaps close up.
// Reset clears only the valid bits; the pipeline is empty and ready right after reset.
`timescale 1ns / 1ps

module cartesian_to_spherical_vector #(
    parameter int CORDIC_ITERATIONS = c2s_pkg::CORDIC_ITER_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // vec_x, vec_y, vec_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // magnitude, polar_angle, azimuth_angle
);
    import c2s_pkg::*;

    localparam int N = (CORDIC_ITERATIONS > MAX_ITER) ? MAX_ITER : CORDIC_ITERATIONS;

    logic signed [15:0]     vec_x;
    logic signed [15:0]     vec_y;
    logic signed [15:0]     vec_z;
    logic signed [DW-1:0]   s1_x;
    logic signed [DW-1:0]   s1_y;

    cvec_t                  a_vec   [N+1];
    logic                   a_valid [N+1];
    logic                   a_ready [N+1];
    logic [SIDE_W-1:0]      a_side  [N+1];
    cvec_t                  b_vec   [N+1];
    logic                   b_valid [N+1];
    logic                   b_ready [N+1];
    logic [SIDE_W-1:0]      b_side  [N+1];

    logic                   g1_valid;
    logic                   g1_ready;
    logic [PW-1:0]          g1_prod;
    logic signed [AW-1:0]   g1_ang;
    logic [SIDE_W-1:0]      g1_side;
    logic [PW:0]            h_sum;
    logic signed [DW-1:0]   s2_x;
    logic signed [DW-1:0]   s2_y;
    logic signed [AW-1:0]   phi_sum;
    logic signed [AW-17:0]  phi_w;
    logic [15:0]            phi;

    logic                   g2_valid;
    logic                   g2_ready;
    logic [PW-1:0]          g2_prod;
    logic signed [AW-1:0]   g2_ang;
    logic [SIDE_W-1:0]      g2_side;
    logic [PW:0]            r_sum;
    logic [DW:0]            m_sum;
    logic [DW-FRAC_BITS:0]  mag_w;
    logic [15:0]            mag;
    logic signed [AW-1:0]   th_sum;
    logic signed [AW-17:0]  th_w;
    logic [15:0]            theta;

    logic                   out_valid_reg;
    logic [47:0]            out_data_reg;
    logic [47:0]            out_data_next;

    assign vec_x = s_tdata[15:0];
    assign vec_y = s_tdata[31:16];
    assign vec_z = s_tdata[47:32];
    assign s1_x  = {{(DW-16-FRAC_BITS){vec_x[15]}}, vec_x, {FRAC_BITS{1'b0}}};
    assign s1_y  = {{(DW-16-FRAC_BITS){vec_y[15]}}, vec_y, {FRAC_BITS{1'b0}}};

    c2s_prerot_cell u_pre1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s1_x),
        .in_y      (s1_y),
        .in_side   (vec_z),
        .out_valid (a_valid[0]),
        .out_ready (a_ready[0]),
        .out_vec   (a_vec[0]),
        .out_side  (a_side[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_chain_a
        c2s_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (a_valid[i]),
            .in_ready  (a_ready[i]),
            .in_vec    (a_vec[i]),
            .in_side   (a_side[i]),
            .out_valid (a_valid[i+1]),
            .out_ready (a_ready[i+1]),
            .out_vec   (a_vec[i+1]),
            .out_side  (a_side[i+1])
        );
    end

    c2s_gain_cell u_gain1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid[N]),
        .in_ready  (a_ready[N]),
        .in_vec    (a_vec[N]),
        .in_side   (a_side[N]),
        .out_valid (g1_valid),
        .out_ready (g1_ready),
        .out_prod  (g1_prod),
        .out_ang   (g1_ang),
        .out_side  (g1_side)
    );

    // The horizontal length is rounded out of the gain product; phi is finished here.
    assign h_sum   = {1'b0, g1_prod} + (PW + 1)'(64'd1 << (GW - 1));
    assign s2_y    = {1'b0, h_sum[PW-1:GW]};
    assign s2_x    = {{(DW-16-FRAC_BITS){g1_side[15]}}, g1_side, {FRAC_BITS{1'b0}}};
    assign phi_sum = g1_ang + AW'(32768);
    assign phi_w   = phi_sum[AW-1:16];

    always_comb
    begin
        if (phi_w > (AW-16)'(32767))
        begin
            phi = 16'h7FFF;
        end
        else if (phi_w < -(AW-16)'(32768))
        begin
            phi = 16'h8000;
        end
        else
        begin
            phi = phi_w[15:0];
        end
    end

    c2s_prerot_cell u_pre2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g1_valid),
        .in_ready  (g1_ready),
        .in_x      (s2_x),
        .in_y      (s2_y),
        .in_side   (phi),
        .out_valid (b_valid[0]),
        .out_ready (b_ready[0]),
        .out_vec   (b_vec[0]),
        .out_side  (b_side[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_chain_b
        c2s_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (b_valid[i]),
            .in_ready  (b_ready[i]),
            .in_vec    (b_vec[i]),
            .in_side   (b_side[i]),
            .out_valid (b_valid[i+1]),
            .out_ready (b_ready[i+1]),
            .out_vec   (b_vec[i+1]),
            .out_side  (b_side[i+1])
        );
    end

    c2s_gain_cell u_gain2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid[N]),
        .in_ready  (b_ready[N]),
        .in_vec    (b_vec[N]),
        .in_side   (b_side[N]),
        .out_valid (g2_valid),
        .out_ready (g2_ready),
        .out_prod  (g2_prod),
        .out_ang   (g2_ang),
        .out_side  (g2_side)
    );

    assign r_sum  = {1'b0, g2_prod} + (PW + 1)'(64'd1 << (GW - 1));
    assign m_sum  = {1'b0, r_sum[PW:GW]} + (DW + 1)'(1 << (FRAC_BITS - 1));
    assign mag_w  = m_sum[DW:FRAC_BITS];
    assign mag    = (mag_w > (DW - FRAC_BITS + 1)'(65535)) ? 16'hFFFF : mag_w[15:0];
    assign th_sum = g2_ang + AW'(32768);
    assign th_w   = th_sum[AW-1:16];

    always_comb
    begin
        if (th_w[AW-17])
        begin
            theta = 16'd0;
        end
        else if (th_w > (AW-16)'(32768))
        begin
            theta = 16'd32768;
        end
        else
        begin
            theta = th_w[15:0];
        end
    end

    assign out_data_next = {g2_side, theta, mag};
    assign g2_ready      = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (g2_ready)
        begin
            out_valid_reg <= g2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (g2_valid && g2_ready)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output register is empty");

    a_accept_fills_entry: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> a_valid[0])
        else $error("accepted vector did not reach the entry cell");

    a_polar_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:16] <= 16'd32768)
        else $error("polar angle above pi");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:0] <= 16'd56756)
        else $error("magnitude beyond the largest possible length");

endmodule

FILE: sv/c2s_prerot_cell.sv
// Entry cell of a vectoring stage: folds the left half-plane onto the right one.
`timescale 1ns / 1ps

module c2s_prerot_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [c2s_pkg::DW-1:0]     in_x,
    input  logic signed [c2s_pkg::DW-1:0]     in_y,
    input  logic [c2s_pkg::SIDE_W-1:0]        in_side,
    output logic                              out_valid,
    input  logic                              out_ready,
    output c2s_pkg::cvec_t                    out_vec,
    output logic [c2s_pkg::SIDE_W-1:0]        out_side
);
    import c2s_pkg::*;

    logic                valid_reg;
    cvec_t               vec_reg;
    cvec_t               vec_next;
    logic [SIDE_W-1:0]   side_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        vec_next.on_axis  = (in_y == '0);
        vec_next.neg_axis = in_x[DW-1];
        vec_next.x        = in_x;
        vec_next.y        = in_y;
        vec_next.ang      = '0;
        if (in_x[DW-1])
        begin
            if (!in_y[DW-1])
            begin
                vec_next.x   = in_y;
                vec_next.y   = -in_x;
                vec_next.ang = ANG_HALF_PI;
            end
            else
            begin
                vec_next.x   = -in_y;
                vec_next.y   = in_x;
                vec_next.ang = -ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

FILE: sv/c2s_cordic_cell.sv
// One CORDIC vectoring micro-rotation with its pipeline register.
`timescale 1ns / 1ps

module c2s_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  c2s_pkg::cvec_t              in_vec,
    input  logic [c2s_pkg::SIDE_W-1:0]  in_side,
    output logic                        out_valid,
    input  logic                        out_ready,
    output c2s_pkg::cvec_t              out_vec,
    output logic [c2s_pkg::SIDE_W-1:0]  out_side
);
    import c2s_pkg::*;

    logic                 valid_reg;
    cvec_t                vec_reg;
    cvec_t                vec_next;
    logic [SIDE_W-1:0]    side_reg;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;

    assign in_ready = !valid_reg || out_ready;
    assign dx       = in_vec.y >>> IDX;
    assign dy       = in_vec.x >>> IDX;

    always_comb
    begin
        vec_next = in_vec;
        if (!in_vec.y[DW-1])
        begin
            vec_next.x   = in_vec.x + dx;
            vec_next.y   = in_vec.y - dy;
            vec_next.ang = in_vec.ang + ATAN_TAB[IDX];
        end
        else
        begin
            vec_next.x   = in_vec.x - dx;
            vec_next.y   = in_vec.y + dy;
            vec_next.ang = in_vec.ang - ATAN_TAB[IDX];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

FILE: sv/c2s_gain_cell.sv
// Exit cell of a vectoring stage: gain product and on-axis angle override.
`timescale 1ns / 1ps

module c2s_gain_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  c2s_pkg::cvec_t                    in_vec,
    input  logic [c2s_pkg::SIDE_W-1:0]        in_side,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [c2s_pkg::PW-1:0]            out_prod,
    output logic signed [c2s_pkg::AW-1:0]     out_ang,
    output logic [c2s_pkg::SIDE_W-1:0]        out_side
);
    import c2s_pkg::*;

    logic                 valid_reg;
    logic [UW-1:0]        len_pos;
    logic [PW-1:0]        prod_reg;
    logic [PW-1:0]        prod_next;
    logic signed [AW-1:0] ang_reg;
    logic signed [AW-1:0] ang_next;
    logic [SIDE_W-1:0]    side_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign len_pos   = in_vec.x[DW-1] ? '0 : in_vec.x[UW-1:0];
    assign prod_next = PW'(len_pos) * PW'(INV_GAIN);

    always_comb
    begin
        ang_next = in_vec.ang;
        if (in_vec.on_axis)
        begin
            ang_next = in_vec.neg_axis ? ANG_PI : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_reg <= prod_next;
            ang_reg  <= ang_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;
    assign out_ang   = ang_reg;
    assign out_side  = side_reg;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the Cartesian-to-spherical vector converter.
`timescale 1ns / 1ps

module testbench;

    localparam int ITERS      = 16;
    localparam int LATENCY    = 2 * ITERS + 5;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_RANDOM   = 850;

    localparam longint ANGLE_PI      = 64'sd2147483648;
    localparam longint ANGLE_HALF_PI = 64'sd1073741824;

    typedef struct packed {
        logic        [15:0] magnitude;
        logic        [15:0] polar_angle;
        logic signed [15:0] azimuth_angle;
    } spherical_t;

    typedef struct {
        spherical_t  coords;
        logic [47:0] source;
    } expectation_t;

    typedef struct {
        logic [47:0] data;
        int          gap;
        bit          drain;
    } vector_item_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    vector_item_t vector_queue[$];
    expectation_t expected_spherical[$];

    int idle_count;
    int stall_left;
    int stall_draw;
    int idle_cycles;
    int mismatches;
    bit steady_rx;

    cartesian_to_spherical_vector #(
        .CORDIC_ITERATIONS(ITERS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // vec_x, vec_y, vec_z
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)    // magnitude, polar_angle, azimuth_angle
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint arctan_step(input int i);
        case (i)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10680862;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            16: return 10430;
            17: return 5215;
            18: return 2608;
            19: return 1304;
            20: return 652;
            21: return 326;
            22: return 163;
            default: return 81;
        endcase
    endfunction

    // Rotates (xi, yi) onto the positive x axis and returns its length and angle.
    function automatic void rotate_to_axis(input longint xi, input longint yi,
                                           output longint len, output longint ang);
        longint x;
        longint y;
        longint a;
        longint t;
        longint dx;
        longint dy;
        int     steps;
        bit     on_axis;
        bit     neg_axis;
        x        = xi;
        y        = yi;
        a        = 0;
        on_axis  = (yi == 0);
        neg_axis = (xi < 0);
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                a = ANGLE_HALF_PI;
            end
            else
            begin
                x = -y;
                y = t;
                a = -ANGLE_HALF_PI;
            end
        end
        steps = (ITERS > 24) ? 24 : ITERS;
        for (int i = 0; i < steps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                a = a + arctan_step(i);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                a = a - arctan_step(i);
            end
        end
        if (on_axis)
            a = neg_axis ? ANGLE_PI : 0;
        len = x;
        ang = a;
    endfunction

    // Removes the CORDIC gain, rounding half up.
    function automatic longint remove_gain(input longint v);
        longint unsigned u;
        u = (v > 0) ? longint'(v) : 0;
        return longint'((u * 64'd652032874 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic spherical_t spherical_of(input logic [47:0] data);
        longint     hraw;
        longint     phi_acc;
        longint     rraw;
        longint     th_acc;
        longint     h;
        longint     r;
        longint     mag;
        longint     phi;
        longint     theta;
        spherical_t res;
        rotate_to_axis(longint'($signed(data[15:0])) * 16384,
                       longint'($signed(data[31:16])) * 16384, hraw, phi_acc);
        h = remove_gain(hraw);
        rotate_to_axis(longint'($signed(data[47:32])) * 16384, h, rraw, th_acc);
        r = remove_gain(rraw);
        mag = (r + 8192) >>> 14;
        if (mag > 65535)
            mag = 65535;
        phi = (phi_acc + 32768) >>> 16;
        if (phi > 32767)
            phi = 32767;
        if (phi < -32768)
            phi = -32768;
        theta = (th_acc + 32768) >>> 16;
        if (theta > 32768)
            theta = 32768;
        if (theta < 0)
            theta = 0;
        res.magnitude     = mag[15:0];
        res.polar_angle   = theta[15:0];
        res.azimuth_angle = phi[15:0];
        return res;
    endfunction

    // Sender: each vector waits out its own gap before it is offered.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            idle_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_spherical.push_back('{spherical_of(s_tdata), s_tdata});
            if (!s_tvalid || s_tready)
            begin
                if (vector_queue.size() != 0 && idle_count >= vector_queue[0].gap &&
                    (!vector_queue[0].drain || expected_spherical.size() == 0))
                begin
                    s_tvalid   <= 1'b1;
                    s_tdata    <= vector_queue[0].data;
                    idle_count <= 0;
                    void'(vector_queue.pop_front());
                end
                else
                begin
                    s_tvalid   <= 1'b0;
                    idle_count <= idle_count + 1;
                end
            end
        end
    end

    // Receiver: checks each transfer and stalls for a random time after it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            steady_rx  <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (expected_spherical.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                if (m_tdata[15:0] !== expected_spherical[0].coords.magnitude)
                begin
                    $display("%0t: magnitude for %h, expected %0d, got %0d", $time,
                             expected_spherical[0].source,
                             expected_spherical[0].coords.magnitude, m_tdata[15:0]);
                    mismatches++;
                end
                if (m_tdata[31:16] !== expected_spherical[0].coords.polar_angle)
                begin
                    $display("%0t: polar angle for %h, expected %0d, got %0d", $time,
                             expected_spherical[0].source,
                             expected_spherical[0].coords.polar_angle, m_tdata[31:16]);
                    mismatches++;
                end
                if (m_tdata[47:32] !== expected_spherical[0].coords.azimuth_angle)
                begin
                    $display("%0t: azimuth for %h, expected %0d, got %0d", $time,
                             expected_spherical[0].source,
                             expected_spherical[0].coords.azimuth_angle,
                             $signed(m_tdata[47:32]));
                    mismatches++;
                end
                void'(expected_spherical.pop_front());
            end
            if ($urandom_range(0, 39) == 0)
                steady_rx <= !steady_rx;
            stall_draw = steady_rx ? 0 : $urandom_range(0, 14);
            stall_left <= stall_draw;
            m_tready   <= (stall_draw == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic queue_vector(input logic [15:0] x, input logic [15:0] y,
                                input logic [15:0] z, input int gap, input bit drain);
        vector_queue.push_back('{{z, y, x}, gap, drain});
    endtask

    function automatic logic [15:0] edge_value();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h8001;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    initial
    begin
        logic [15:0] comp [3];
        int          kind;
        int          zero_mask;
        int          gap;
        bit          calm;

        idle_cycles = 0;
        mismatches  = 0;

        // Zero vector, each axis in both directions, and the extremes.
        queue_vector(16'h0000, 16'h0000, 16'h0000, 0, 1'b0);
        queue_vector(16'h7FFF, 16'h0000, 16'h0000, 0, 1'b0);
        queue_vector(16'h8000, 16'h0000, 16'h0000, 0, 1'b0);
        queue_vector(16'h0000, 16'h7FFF, 16'h0000, 0, 1'b0);
        queue_vector(16'h0000, 16'h8000, 16'h0000, 0, 1'b0);
        queue_vector(16'h0000, 16'h0000, 16'h7FFF, 0, 1'b0);
        queue_vector(16'h0000, 16'h0000, 16'h8000, 3, 1'b0);
        queue_vector(16'h0000, 16'h0000, 16'hFFFF, 0, 1'b0);
        queue_vector(16'hFFFF, 16'h0000, 16'h0000, 0, 1'b0);
        queue_vector(16'h8000, 16'h8000, 16'h8000, 0, 1'b0);
        queue_vector(16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 1'b0);
        queue_vector(16'h8000, 16'h7FFF, 16'h8000, 5, 1'b0);
        queue_vector(16'h7FFF, 16'h8000, 16'h7FFF, 0, 1'b0);
        queue_vector(16'h8000, 16'hFFFF, 16'h0000, 0, 1'b0);
        queue_vector(16'h8000, 16'h0001, 16'h0000, 0, 1'b0);
        queue_vector(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1'b0);
        queue_vector(16'h0001, 16'h0001, 16'h0001, 14, 1'b0);
        queue_vector(16'h0001, 16'hFFFF, 16'h8000, 0, 1'b0);
        queue_vector(16'h8000, 16'h8000, 16'h7FFF, 0, 1'b0);
        queue_vector(16'h1234, 16'hEDCC, 16'h0000, 0, 1'b0);
        queue_vector(16'h0000, 16'h0001, 16'h8000, 0, 1'b1);

        calm = 1'b0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 60 == 0)
                calm = ($urandom_range(0, 2) == 0);
            kind = $urandom_range(0, 19);
            for (int k = 0; k < 3; k++)
            begin
                if (kind < 10)
                    comp[k] = 16'($urandom_range(0, 65535));
                else if (kind < 14)
                    comp[k] = 16'($urandom_range(0, 16) - 8);
                else if (kind < 17)
                    comp[k] = 16'($urandom_range(0, 65535));
                else
                    comp[k] = edge_value();
            end
            if (kind >= 14 && kind < 17)
            begin
                zero_mask = $urandom_range(1, 6);
                for (int k = 0; k < 3; k++)
                    if (zero_mask[k])
                        comp[k] = 16'h0000;
            end
            gap = calm ? 0 : $urandom_range(0, 14);
            queue_vector(comp[0], comp[1], comp[2], gap, n == N_RANDOM / 2);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (vector_queue.size() != 0 || s_tvalid || expected_spherical.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
